// ----- sv/lru_replacement_tracker_top_defines.svh -----
// Assertion macros used by the LRU tracker checker.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef LRU_REPLACEMENT_TRACKER_TOP_DEFINES_SVH
`define LRU_REPLACEMENT_TRACKER_TOP_DEFINES_SVH

// Same-cycle implication, ignored while in reset.
`define LRT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while in reset.
`define LRT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define LRT_ASSERT_RST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lrt_pkg.sv -----
// Package for the LRU replacement tracker: sizes, request kinds, status codes.
// No dependencies.
package lrt_pkg;

    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 64;

    localparam int KIND_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 2;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

    localparam logic [KIND_W-1:0] KIND_INSERT      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCESS      = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EVICT_LRU   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_EVICT_NAMED = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_BADSLOT  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [KEY_W-1:0]  key;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   out_slot;
        logic [KEY_W-1:0]    out_key;
    } t_rsp;

endpackage

// ----- sv/lrt_req_if.sv -----
// Request channel of the LRU tracker: valid/ready plus kind, slot and key.
// Depends on lrt_pkg.
interface lrt_req_if;
    logic                         valid;
    logic                         ready;
    logic [lrt_pkg::KIND_W-1:0]   kind;
    logic [lrt_pkg::SLOT_W-1:0]   slot;
    logic [lrt_pkg::KEY_W-1:0]    key;

    modport source (output valid, kind, slot, key, input ready);
    modport sink   (input valid, kind, slot, key, output ready);
endinterface

// ----- sv/lrt_rsp_if.sv -----
// Response channel of the LRU tracker: valid/ready plus status, slot and key.
// Depends on lrt_pkg.
interface lrt_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [lrt_pkg::STATUS_W-1:0] status;
    logic [lrt_pkg::SLOT_W-1:0]   out_slot;
    logic [lrt_pkg::KEY_W-1:0]    out_key;

    modport source (output valid, status, out_slot, out_key, input ready);
    modport sink   (input valid, status, out_slot, out_key, output ready);
endinterface

// ----- sv/lru_replacement_tracker_top.sv -----
// LRU replacement tracker: one request in, one response out.
// Pipeline: request register, then response register. Throughput 1 request per cycle while
// the response is not stalled by o_rsp.ready, set by the combinational rank update.
// Reset (sync, active low) clears the valid map, ranks, occupancy count and the valid bits of
// both pipeline registers; stored keys are not reset and are read only for occupied slots.
// Depends on lrt_pkg, lrt_req_if, lrt_rsp_if.
module lru_replacement_tracker_top (
    input logic        i_clk,
    input logic        i_rst_n,
    lrt_req_if.sink    i_req,
    lrt_rsp_if.source  o_rsp
);

    localparam int ENTRIES  = lrt_pkg::ENTRIES;
    localparam int KEY_BITS = lrt_pkg::KEY_BITS;
    localparam int IDX_W    = lrt_pkg::IDX_W;
    localparam int CNT_W    = lrt_pkg::CNT_W;
    localparam int CMP_W    = lrt_pkg::CMP_W;

    logic                   r_req_valid;
    lrt_pkg::t_req          r_req;
    logic                   r_rsp_valid;
    lrt_pkg::t_rsp          r_rsp;

    logic [ENTRIES-1:0]     r_slot_valid;
    logic [IDX_W-1:0]       r_rank [ENTRIES];
    logic [KEY_BITS-1:0]    r_key  [ENTRIES];
    logic [CNT_W-1:0]       r_count;

    logic [ENTRIES-1:0]     n_slot_valid;
    logic [IDX_W-1:0]       n_rank [ENTRIES];
    logic [CNT_W-1:0]       n_count;
    lrt_pkg::t_rsp          n_rsp;

    logic                   advance;
    logic                   req_take;
    logic [KEY_BITS-1:0]    req_key;
    logic [CMP_W-1:0]       slot_ext;
    logic                   in_range;
    logic [IDX_W-1:0]       slot_idx;
    logic                   occupied;
    logic [IDX_W-1:0]       lru_rank;
    logic [IDX_W-1:0]       lru_idx;
    logic                   lru_found;
    logic [IDX_W-1:0]       tgt_idx;
    logic [IDX_W-1:0]       tgt_rank;
    logic [KEY_BITS-1:0]    tgt_key;
    logic                   do_insert;
    logic                   do_front;
    logic                   do_evict;
    logic [CMP_W-1:0]       out_slot_ext;

    assign advance  = r_req_valid && (!r_rsp_valid || o_rsp.ready);
    assign req_take = i_req.valid && i_req.ready;
    assign i_req.ready = !r_req_valid || advance;

    assign req_key  = r_req.key[KEY_BITS-1:0];
    assign slot_ext = CMP_W'(r_req.slot);
    assign in_range = slot_ext < CMP_W'(ENTRIES);
    assign slot_idx = slot_ext[IDX_W-1:0];
    assign occupied = in_range && r_slot_valid[slot_idx];

    // Least recent slot carries rank count-1; occupied ranks are gap-free.
    assign lru_rank = IDX_W'(r_count - CNT_W'(1));

    always_comb begin
        lru_idx   = '0;
        lru_found = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!lru_found && r_slot_valid[i] && r_rank[i] == lru_rank) begin
                lru_idx   = IDX_W'(i);
                lru_found = 1'b1;
            end
        end
    end

    assign tgt_idx  = (r_req.kind == lrt_pkg::KIND_EVICT_LRU) ? lru_idx : slot_idx;
    assign tgt_rank = r_rank[tgt_idx];
    assign tgt_key  = r_key[tgt_idx];

    always_comb begin
        do_insert       = 1'b0;
        do_front        = 1'b0;
        do_evict        = 1'b0;
        n_rsp.status    = lrt_pkg::STATUS_OK;
        n_rsp.out_key   = '0;
        out_slot_ext    = slot_ext;
        unique case (r_req.kind)
            lrt_pkg::KIND_INSERT: begin
                if (!in_range || occupied) begin
                    n_rsp.status = lrt_pkg::STATUS_BADSLOT;
                end else begin
                    do_insert = 1'b1;
                end
            end
            lrt_pkg::KIND_ACCESS: begin
                if (!occupied) begin
                    n_rsp.status = lrt_pkg::STATUS_BADSLOT;
                end else if (tgt_key != req_key) begin
                    n_rsp.status = lrt_pkg::STATUS_MISMATCH;
                end else begin
                    do_front = 1'b1;
                end
            end
            lrt_pkg::KIND_EVICT_LRU: begin
                out_slot_ext = '0;
                if (r_count == '0) begin
                    n_rsp.status = lrt_pkg::STATUS_EMPTY;
                end else begin
                    do_evict      = 1'b1;
                    out_slot_ext  = CMP_W'(lru_idx);
                    n_rsp.out_key = lrt_pkg::KEY_W'(tgt_key);
                end
            end
            lrt_pkg::KIND_EVICT_NAMED: begin
                if (!occupied) begin
                    n_rsp.status = lrt_pkg::STATUS_BADSLOT;
                end else begin
                    do_evict      = 1'b1;
                    n_rsp.out_key = lrt_pkg::KEY_W'(tgt_key);
                end
            end
            default: begin
                n_rsp.status = lrt_pkg::STATUS_BADSLOT;
            end
        endcase
        n_rsp.out_slot = out_slot_ext[lrt_pkg::SLOT_W-1:0];
    end

    // Per-slot rank update; every slot compares against the target rank in parallel.
    always_comb begin
        n_slot_valid = r_slot_valid;
        n_count      = r_count;
        for (int i = 0; i < ENTRIES; i++) begin
            n_rank[i] = r_rank[i];
            if (IDX_W'(i) == tgt_idx) begin
                if (do_insert || do_front) begin
                    n_rank[i] = '0;
                end
                if (do_insert) begin
                    n_slot_valid[i] = 1'b1;
                end
                if (do_evict) begin
                    n_slot_valid[i] = 1'b0;
                    n_rank[i]       = '0;
                end
            end else if (r_slot_valid[i]) begin
                if (do_insert || (do_front && r_rank[i] < tgt_rank)) begin
                    n_rank[i] = r_rank[i] + IDX_W'(1);
                end else if (do_evict && r_rank[i] > tgt_rank) begin
                    n_rank[i] = r_rank[i] - IDX_W'(1);
                end
            end
        end
        if (do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_evict) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid  <= 1'b0;
            r_rsp_valid  <= 1'b0;
            r_slot_valid <= '0;
            r_count      <= '0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (req_take) begin
                r_req_valid <= 1'b1;
            end else if (advance) begin
                r_req_valid <= 1'b0;
            end
            r_rsp_valid <= advance || (r_rsp_valid && !o_rsp.ready);
            if (advance) begin
                r_slot_valid <= n_slot_valid;
                r_count      <= n_count;
                for (int i = 0; i < ENTRIES; i++) begin
                    r_rank[i] <= n_rank[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_req.kind <= i_req.kind;
            r_req.slot <= i_req.slot;
            r_req.key  <= i_req.key;
        end
        if (advance) begin
            r_rsp <= n_rsp;
        end
        if (advance && do_insert) begin
            r_key[slot_idx] <= req_key;
        end
    end

    assign o_rsp.valid    = r_rsp_valid;
    assign o_rsp.status   = r_rsp.status;
    assign o_rsp.out_slot = r_rsp.out_slot;
    assign o_rsp.out_key  = r_rsp.out_key;

endmodule

// ----- sv/lrt_checker.sv -----
// Port-level checker for the LRU tracker, bound to the top level.
// Depends on lrt_pkg and lru_replacement_tracker_top_defines.svh.
`include "lru_replacement_tracker_top_defines.svh"

module lrt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [lrt_pkg::STATUS_W-1:0] i_rsp_status,
    input logic [lrt_pkg::SLOT_W-1:0]   i_rsp_out_slot,
    input logic [lrt_pkg::KEY_W-1:0]    i_rsp_out_key
);

    // Stalled response keeps its contents.
    `LRT_ASSERT_NEXT(a_rsp_hold, i_rsp_valid && !i_rsp_ready,
        i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_out_slot)
            && $stable(i_rsp_out_key),
        "response changed while stalled")

    // Out of reset: pipeline empty and ready for a request.
    `LRT_ASSERT_RST_NEXT(a_rst_clear, !i_rst_n, !i_rsp_valid && i_req_ready,
        "pipeline not cleared by reset")

    // Failed requests never return a key.
    `LRT_ASSERT_SAME(a_err_no_key, i_rsp_valid && i_rsp_status != lrt_pkg::STATUS_OK,
        i_rsp_out_key == '0, "error response carries a key")

    // Evicting from an empty tracker reports slot zero.
    `LRT_ASSERT_SAME(a_empty_slot, i_rsp_valid && i_rsp_status == lrt_pkg::STATUS_EMPTY,
        i_rsp_out_slot == '0, "empty evict reports nonzero slot")

endmodule

bind lru_replacement_tracker_top lrt_checker u_lrt_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_req_ready    (i_req.ready),
    .i_rsp_valid    (o_rsp.valid),
    .i_rsp_ready    (o_rsp.ready),
    .i_rsp_status   (o_rsp.status),
    .i_rsp_out_slot (o_rsp.out_slot),
    .i_rsp_out_key  (o_rsp.out_key)
);
